// File: hdl/ccvd_pkg.sv
package ccvd_pkg;

  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned ENABLE_W   = 4;
  localparam int unsigned COLUMN_W   = 6;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

  localparam logic [SIZE_W-1:0]   CELL_SIZE_RST     = 7'd16;
  localparam logic [SIZE_W-1:0]   CELLS_PER_ROW_RST = 7'd16;

  // color_enable bit positions
  localparam int unsigned EN_EMPTY_A = 0;
  localparam int unsigned EN_EMPTY_B = 1;
  localparam int unsigned EN_FULL_A  = 2;
  localparam int unsigned EN_FULL_B  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE     = 3'd0,
    REG_CELLS_PER_ROW = 3'd1,
    REG_EMPTY_COLOR_A = 3'd2,
    REG_EMPTY_COLOR_B = 3'd3,
    REG_FULL_COLOR_A  = 3'd4,
    REG_FULL_COLOR_B  = 3'd5,
    REG_COLOR_ENABLE  = 3'd6
  } reg_index_t;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    count_t empty_cnt;
    count_t full_cnt;
  } count_pair_t;

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

// File: hdl/ccvd_pixel_if.sv
interface ccvd_pixel_if;
  logic                           valid;
  logic                           ready;
  logic [ccvd_pkg::COLOR_W-1:0]   pixel_rgb;
  logic                           frame_start;

  modport source (output valid, output pixel_rgb, output frame_start, input ready);
  modport sink   (input valid, input pixel_rgb, input frame_start, output ready);
endinterface

// File: hdl/ccvd_cell_if.sv
interface ccvd_cell_if;
  logic                           valid;
  logic                           ready;
  logic                           cell_is_full;
  logic [ccvd_pkg::COLUMN_W-1:0]  cell_column;
  logic                           last_in_row;

  modport source (output valid, output cell_is_full, output cell_column,
                  output last_in_row, input ready);
  modport sink   (input valid, input cell_is_full, input cell_column,
                  input last_in_row, output ready);
endinterface

// File: hdl/ccvd_cfg_if.sv
interface ccvd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ccvd_pkg::CFG_IDX_W-1:0]  index;
  logic [ccvd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/cell_color_vote_downsampler_unit.sv
// Path: after the beat of a cell's bottom-right pixel, the cell result passes the
//   column store read and then the result register, from which it leaves.
// Throughput: one pixel beat per cycle; the store is read once per beat and written
//   at most once. A result held off stops pixel beats once stage 1 backs up.
// Reset (rst, synchronous): clears raster position, running counts, pipeline
//   valids and the registers to their defaults. The column store is not cleared.
module cell_color_vote_downsampler_unit #(
  parameter int unsigned MAX_CELL_SIZE     = 64,
  parameter int unsigned MAX_CELLS_PER_ROW = 64
) (
  input  logic         clk,
  input  logic         rst,
  ccvd_pixel_if.sink   pixel,
  ccvd_cell_if.source  result,
  ccvd_cfg_if.sink     cfg
);

  // position counter widths hold their limit; store address covers the depth
  localparam int unsigned PW = $clog2(MAX_CELL_SIZE + 1);
  localparam int unsigned CW = $clog2(MAX_CELLS_PER_ROW + 1);
  localparam int unsigned AW = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ccvd_pkg::SIZE_W-1:0]   cell_size;
  logic [ccvd_pkg::SIZE_W-1:0]   cells_per_row;
  logic [ccvd_pkg::COLOR_W-1:0]  empty_color_a;
  logic [ccvd_pkg::COLOR_W-1:0]  empty_color_b;
  logic [ccvd_pkg::COLOR_W-1:0]  full_color_a;
  logic [ccvd_pkg::COLOR_W-1:0]  full_color_b;
  logic [ccvd_pkg::ENABLE_W-1:0] color_enable;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size     <= ccvd_pkg::CELL_SIZE_RST;
      cells_per_row <= ccvd_pkg::CELLS_PER_ROW_RST;
      empty_color_a <= '0;
      empty_color_b <= '0;
      full_color_a  <= '0;
      full_color_b  <= '0;
      color_enable  <= '0;
    end else if (cfg.valid) begin
      case (ccvd_pkg::reg_index_t'(cfg.index))
        ccvd_pkg::REG_CELL_SIZE:     cell_size     <= cfg.data[ccvd_pkg::SIZE_W-1:0];
        ccvd_pkg::REG_CELLS_PER_ROW: cells_per_row <= cfg.data[ccvd_pkg::SIZE_W-1:0];
        ccvd_pkg::REG_EMPTY_COLOR_A: empty_color_a <= cfg.data[ccvd_pkg::COLOR_W-1:0];
        ccvd_pkg::REG_EMPTY_COLOR_B: empty_color_b <= cfg.data[ccvd_pkg::COLOR_W-1:0];
        ccvd_pkg::REG_FULL_COLOR_A:  full_color_a  <= cfg.data[ccvd_pkg::COLOR_W-1:0];
        ccvd_pkg::REG_FULL_COLOR_B:  full_color_b  <= cfg.data[ccvd_pkg::COLOR_W-1:0];
        ccvd_pkg::REG_COLOR_ENABLE:  color_enable  <= cfg.data[ccvd_pkg::ENABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits: zero acts as one, oversize clamps to the maximum
  logic [PW-1:0] cs_eff;
  logic [CW-1:0] cpr_eff;

  always_comb begin
    if (cell_size == '0) begin
      cs_eff = PW'(1);
    end else if (32'(cell_size) > MAX_CELL_SIZE) begin
      cs_eff = PW'(MAX_CELL_SIZE);
    end else begin
      cs_eff = PW'(cell_size);
    end
    if (cells_per_row == '0) begin
      cpr_eff = CW'(1);
    end else if (32'(cells_per_row) > MAX_CELLS_PER_ROW) begin
      cpr_eff = CW'(MAX_CELLS_PER_ROW);
    end else begin
      cpr_eff = CW'(cells_per_row);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: colour match, running counts, raster position, store read
  // ---------------------------------------------------------------------------
  logic [PW-1:0]          pixel_in_cell;
  logic [CW-1:0]          column_of_cell;
  logic [PW-1:0]          line_in_cell;
  ccvd_pkg::count_t       running_empty;
  ccvd_pkg::count_t       running_full;

  logic                   in_accept;
  logic [PW-1:0]          pic_cur;
  logic [CW-1:0]          col_cur;
  logic [PW-1:0]          line_cur;
  ccvd_pkg::count_t       run_e_cur;
  ccvd_pkg::count_t       run_f_cur;
  logic                   is_empty;
  logic                   is_full;
  ccvd_pkg::count_t       run_e_next;
  ccvd_pkg::count_t       run_f_next;
  logic                   seg_end;
  logic                   last_col;
  logic                   last_line;
  logic [AW-1:0]          rd_addr;

  // frame start restarts position and running counts before this pixel
  assign pic_cur   = pixel.frame_start ? '0 : pixel_in_cell;
  assign col_cur   = pixel.frame_start ? '0 : column_of_cell;
  assign line_cur  = pixel.frame_start ? '0 : line_in_cell;
  assign run_e_cur = pixel.frame_start ? '0 : running_empty;
  assign run_f_cur = pixel.frame_start ? '0 : running_full;

  assign is_empty =
    (color_enable[ccvd_pkg::EN_EMPTY_A] && (pixel.pixel_rgb == empty_color_a)) ||
    (color_enable[ccvd_pkg::EN_EMPTY_B] && (pixel.pixel_rgb == empty_color_b));
  assign is_full =
    (color_enable[ccvd_pkg::EN_FULL_A] && (pixel.pixel_rgb == full_color_a)) ||
    (color_enable[ccvd_pkg::EN_FULL_B] && (pixel.pixel_rgb == full_color_b));

  assign run_e_next = ccvd_pkg::sat_add(run_e_cur, ccvd_pkg::count_t'(is_empty));
  assign run_f_next = ccvd_pkg::sat_add(run_f_cur, ccvd_pkg::count_t'(is_full));

  // "at or past the limit" covers a limit lowered mid-frame
  assign seg_end   = ((PW+1)'(pic_cur) + (PW+1)'(1)) >= (PW+1)'(cs_eff);
  assign last_col  = ((CW+1)'(col_cur) + (CW+1)'(1)) >= (CW+1)'(cpr_eff);
  assign last_line = ((PW+1)'(line_cur) + (PW+1)'(1)) >= (PW+1)'(cs_eff);
  assign rd_addr   = AW'(col_cur);

  // ---------------------------------------------------------------------------
  // Stage 1 registers (segment end in flight) and output register
  // ---------------------------------------------------------------------------
  logic                   s1_valid;
  logic                   s1_out;       // last line of cell: give result, no write
  logic                   s1_first;     // first line of cell row: stored count ignored
  logic                   s1_last_col;
  logic [AW-1:0]          s1_col;
  ccvd_pkg::count_t       s1_run_e;
  ccvd_pkg::count_t       s1_run_f;
  logic                   s1_move;

  logic                   fwd;
  ccvd_pkg::count_pair_t  fwd_data;
  ccvd_pkg::count_pair_t  rd_data;

  logic                   out_valid;
  logic                   out_full;
  logic [ccvd_pkg::COLUMN_W-1:0] out_col;
  logic                   out_last;

  assign s1_move     = !s1_out || !out_valid || result.ready;
  assign pixel.ready = !s1_valid || s1_move;
  assign in_accept   = pixel.valid && pixel.ready;

  // totals: stored count (forwarded on a same-column write) plus this segment
  ccvd_pkg::count_pair_t  base;
  ccvd_pkg::count_pair_t  totals;
  logic                   mem_we;

  assign base = fwd ? fwd_data : rd_data;

  always_comb begin
    if (s1_first) begin
      totals.empty_cnt = s1_run_e;
      totals.full_cnt  = s1_run_f;
    end else begin
      totals.empty_cnt = ccvd_pkg::sat_add(base.empty_cnt, s1_run_e);
      totals.full_cnt  = ccvd_pkg::sat_add(base.full_cnt, s1_run_f);
    end
  end

  assign mem_we = s1_valid && !s1_out;

  // ---------------------------------------------------------------------------
  // Column store: {empty, full} per cell column, one read and one write port
  // ---------------------------------------------------------------------------
  ccvd_pkg::count_pair_t col_mem [MAX_CELLS_PER_ROW];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[s1_col] <= totals;
    end
    if (in_accept) begin
      rd_data <= col_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_in_cell  <= '0;
      column_of_cell <= '0;
      line_in_cell   <= '0;
      running_empty  <= '0;
      running_full   <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      fwd            <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= seg_end;
        fwd      <= mem_we && (s1_col == rd_addr);
        if (!seg_end) begin
          pixel_in_cell <= pic_cur + PW'(1);
          running_empty <= run_e_next;
          running_full  <= run_f_next;
        end else begin
          pixel_in_cell <= '0;
          running_empty <= '0;
          running_full  <= '0;
          if (last_col) begin
            column_of_cell <= '0;
            line_in_cell   <= last_line ? '0 : line_cur + PW'(1);
          end else begin
            column_of_cell <= col_cur + CW'(1);
            line_in_cell   <= line_cur;
          end
        end
        if (!seg_end) begin
          column_of_cell <= col_cur;
          line_in_cell   <= line_cur;
        end
      end else if (s1_valid && s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && s1_out && s1_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_out      <= last_line;
      s1_first    <= (line_cur == '0);
      s1_last_col <= last_col;
      s1_col      <= rd_addr;
      s1_run_e    <= run_e_next;
      s1_run_f    <= run_f_next;
      fwd_data    <= totals;
    end
    if (s1_valid && s1_out && s1_move) begin
      // ties, zero against zero too, vote full
      out_full <= !(totals.empty_cnt > totals.full_cnt);
      out_col  <= ccvd_pkg::COLUMN_W'(s1_col);
      out_last <= s1_last_col;
    end
  end

  assign result.valid        = out_valid;
  assign result.cell_is_full = out_full;
  assign result.cell_column  = out_col;
  assign result.last_in_row  = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_out && out_valid && !result.ready) |-> !pixel.ready)
    else $error("pixel taken while a cell result is blocked");

  a_seg_end_enters_s1: assert property (@(posedge clk) disable iff (rst)
    (in_accept && seg_end) |=> s1_valid)
    else $error("segment end lost before column store update");

  a_pixel_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pixel_in_cell) < MAX_CELL_SIZE)
    else $error("pixel counter beyond largest cell");

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    32'(column_of_cell) < MAX_CELLS_PER_ROW)
    else $error("cell column beyond store depth");

endmodule

// File: dv/tb_cell_color_vote_downsampler_unit.sv
`timescale 1ns / 100ps

module tb_cell_color_vote_downsampler_unit;

  // Block limits, kept equal to the defaults of the unit.
  localparam int unsigned CELL_EDGE_MAX = 64;
  localparam int unsigned CELL_COLS_MAX = 64;

  // Margin after the last result before the register port is touched again.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 16;
  // Long receiver hold-off, long enough to back the pixel stream right up.
  localparam int unsigned LONG_HOLD     = 300;
  // Timeout limit; gives the slowest sane run plenty of room.
  localparam int unsigned CYCLE_LIMIT   = 1200000;
  localparam int unsigned RANDOM_PIXELS = 450;

  typedef struct {
    logic [ccvd_pkg::COLOR_W-1:0] rgb;
    logic                         frame_start;
    int unsigned                  gap;
  } pixel_job_t;

  typedef struct packed {
    logic                          is_full;
    logic [ccvd_pkg::COLUMN_W-1:0] column;
    logic                          last_cell;
  } cell_vote_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccvd_pixel_if pix_if ();
  ccvd_cell_if  cell_if ();
  ccvd_cfg_if   cfg_if ();

  cell_color_vote_downsampler_unit #(
    .MAX_CELL_SIZE     (CELL_EDGE_MAX),
    .MAX_CELLS_PER_ROW (CELL_COLS_MAX)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (cell_if),
    .cfg    (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  pixel_job_t  pixel_jobs[$];      // pixel beats waiting to be offered
  cell_vote_t  pending_votes[$];   // cell results still owed by the block
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned fault_count   = 0;
  int unsigned cycles_run    = 0;

  logic pixel_beat_seen = 1'b0;    // pixel beat at the last rising edge
  logic cfg_beat_seen   = 1'b0;    // register beat at the last rising edge

  // Colors currently programmed, used to steer the pixel stimulus.
  logic [ccvd_pkg::COLOR_W-1:0] stim_colors[4] = '{default: '0};

  // Long hold-off requests from the stimulus, served by the ready process.
  int unsigned holds_asked = 0;
  int unsigned holds_done  = 0;

  // ---------------------------------------------------------------------------
  // Predictor: register copy and raster state of the block
  // ---------------------------------------------------------------------------
  logic [ccvd_pkg::SIZE_W-1:0]   size_reg    = ccvd_pkg::CELL_SIZE_RST;
  logic [ccvd_pkg::SIZE_W-1:0]   cols_reg    = ccvd_pkg::CELLS_PER_ROW_RST;
  logic [ccvd_pkg::COLOR_W-1:0]  empty_a_reg = '0;
  logic [ccvd_pkg::COLOR_W-1:0]  empty_b_reg = '0;
  logic [ccvd_pkg::COLOR_W-1:0]  full_a_reg  = '0;
  logic [ccvd_pkg::COLOR_W-1:0]  full_b_reg  = '0;
  logic [ccvd_pkg::ENABLE_W-1:0] enable_reg  = '0;

  logic [ccvd_pkg::COLUMN_W-1:0] px_pos   = '0;   // pixel within the cell's line segment
  logic [ccvd_pkg::COLUMN_W-1:0] col_pos  = '0;   // cell column
  logic [ccvd_pkg::COLUMN_W-1:0] line_pos = '0;   // line within the cell row
  ccvd_pkg::count_t              run_empty = '0;
  ccvd_pkg::count_t              run_full  = '0;
  ccvd_pkg::count_t              empty_store[CELL_COLS_MAX] = '{default: '0};
  ccvd_pkg::count_t              full_store[CELL_COLS_MAX]  = '{default: '0};

  // Zero acts as one, anything past the limit acts as the limit.
  function automatic int unsigned clip_limit(input logic [ccvd_pkg::SIZE_W-1:0] v,
                                             input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic ccvd_pkg::count_t add_clip(input ccvd_pkg::count_t a,
                                                input ccvd_pkg::count_t b);
    int unsigned total;
    total = int'(a) + int'(b);
    if (total > int'(ccvd_pkg::COUNT_MAX)) return ccvd_pkg::COUNT_MAX;
    return ccvd_pkg::count_t'(total);
  endfunction

  // One accepted pixel beat: update the raster state and, at a cell's
  // bottom-right pixel, queue the vote the block has to give.
  task automatic tally_pixel(input logic [ccvd_pkg::COLOR_W-1:0] rgb, input logic fs);
    int unsigned                   lim_size;
    int unsigned                   lim_cols;
    logic                          hit_empty;
    logic                          hit_full;
    logic                          col_end;
    logic                          row_end;
    logic [ccvd_pkg::COLUMN_W-1:0] slot;
    ccvd_pkg::count_t              sum_empty;
    ccvd_pkg::count_t              sum_full;
    cell_vote_t                    vote;
    lim_size = clip_limit(size_reg, CELL_EDGE_MAX);
    lim_cols = clip_limit(cols_reg, CELL_COLS_MAX);

    // frame start restarts the raster before this pixel is counted
    if (fs) begin
      px_pos    = '0;
      col_pos   = '0;
      line_pos  = '0;
      run_empty = '0;
      run_full  = '0;
    end

    // a color in both sets counts for both
    hit_empty = (enable_reg[ccvd_pkg::EN_EMPTY_A] && rgb == empty_a_reg) ||
                (enable_reg[ccvd_pkg::EN_EMPTY_B] && rgb == empty_b_reg);
    hit_full  = (enable_reg[ccvd_pkg::EN_FULL_A] && rgb == full_a_reg) ||
                (enable_reg[ccvd_pkg::EN_FULL_B] && rgb == full_b_reg);
    if (hit_empty) run_empty = add_clip(run_empty, ccvd_pkg::count_t'(1));
    if (hit_full)  run_full  = add_clip(run_full, ccvd_pkg::count_t'(1));

    if (int'(px_pos) + 1 < lim_size) begin
      px_pos = px_pos + 1'b1;
    end else begin
      // segment done; a counter at or past a shrunk limit ends here as well
      px_pos  = '0;
      slot    = col_pos;
      col_end = int'(col_pos) + 1 >= lim_cols;
      row_end = int'(line_pos) + 1 >= lim_size;

      // first line of a cell row takes the store as cleared
      if (line_pos == '0) begin
        sum_empty = run_empty;
        sum_full  = run_full;
      end else begin
        sum_empty = add_clip(empty_store[slot], run_empty);
        sum_full  = add_clip(full_store[slot], run_full);
      end
      run_empty = '0;
      run_full  = '0;

      if (row_end) begin
        // empty only on a strict majority, so a tie (0 vs 0 too) is full
        vote.is_full   = !(sum_empty > sum_full);
        vote.column    = slot;
        vote.last_cell = col_end;
        pending_votes.push_back(vote);
      end else begin
        empty_store[slot] = sum_empty;
        full_store[slot]  = sum_full;
      end

      if (col_end) begin
        col_pos  = '0;
        line_pos = row_end ? '0 : line_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end
  endtask

  task automatic check_vote();
    cell_vote_t want;
    if (pending_votes.size() == 0) begin
      $error("cell result with none expected: full %0b column %0d last %0b",
             cell_if.cell_is_full, cell_if.cell_column, cell_if.last_in_row);
      fault_count++;
    end else begin
      want = pending_votes.pop_front();
      if (cell_if.cell_is_full !== want.is_full) begin
        $error("cell_is_full: expected %0b, got %0b", want.is_full, cell_if.cell_is_full);
        fault_count++;
      end
      if (cell_if.cell_column !== want.column) begin
        $error("cell_column: expected %0d, got %0d", want.column, cell_if.cell_column);
        fault_count++;
      end
      if (cell_if.last_in_row !== want.last_cell) begin
        $error("last_in_row: expected %0b, got %0b", want.last_cell, cell_if.last_in_row);
        fault_count++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge. Register beats land in
  // the predictor copy, pixel beats feed the predictor, result beats are
  // checked against the oldest owed vote.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (rst) begin
      pixel_beat_seen <= 1'b0;
      cfg_beat_seen   <= 1'b0;
    end else begin
      pixel_beat_seen <= pix_if.valid && pix_if.ready;
      cfg_beat_seen   <= cfg_if.valid && cfg_if.ready;

      if (cfg_if.valid && cfg_if.ready) begin
        case (ccvd_pkg::reg_index_t'(cfg_if.index))
          ccvd_pkg::REG_CELL_SIZE:     size_reg    = cfg_if.data[ccvd_pkg::SIZE_W-1:0];
          ccvd_pkg::REG_CELLS_PER_ROW: cols_reg    = cfg_if.data[ccvd_pkg::SIZE_W-1:0];
          ccvd_pkg::REG_EMPTY_COLOR_A: empty_a_reg = cfg_if.data[ccvd_pkg::COLOR_W-1:0];
          ccvd_pkg::REG_EMPTY_COLOR_B: empty_b_reg = cfg_if.data[ccvd_pkg::COLOR_W-1:0];
          ccvd_pkg::REG_FULL_COLOR_A:  full_a_reg  = cfg_if.data[ccvd_pkg::COLOR_W-1:0];
          ccvd_pkg::REG_FULL_COLOR_B:  full_b_reg  = cfg_if.data[ccvd_pkg::COLOR_W-1:0];
          ccvd_pkg::REG_COLOR_ENABLE:  enable_reg  = cfg_if.data[ccvd_pkg::ENABLE_W-1:0];
          default: ;
        endcase
      end

      // predict first so a vote would already be owed on a same-edge result
      if (pix_if.valid && pix_if.ready) begin
        pixels_taken++;
        tally_pixel(pix_if.pixel_rgb, pix_if.frame_start);
      end

      if (cell_if.valid && cell_if.ready) check_vote();
    end
  end

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver: takes jobs from the queue, waits out each job's gap, then
  // holds the beat until the block takes it. Changes on the falling edge.
  // ---------------------------------------------------------------------------
  pixel_job_t  staged;
  bit          staged_ok   = 1'b0;
  int unsigned staged_wait = 0;

  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pixel_beat_seen) begin
      if (!staged_ok && pixel_jobs.size() != 0) begin
        staged      = pixel_jobs.pop_front();
        staged_ok   = 1'b1;
        staged_wait = staged.gap;
      end
      if (staged_ok && staged_wait == 0) begin
        pix_if.valid       <= 1'b1;
        pix_if.pixel_rgb   <= staged.rgb;
        pix_if.frame_start <= staged.frame_start;
        staged_ok = 1'b0;
      end else begin
        pix_if.valid <= 1'b0;
        if (staged_ok) staged_wait--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: alternating runs of ready and stall, with the occasional
  // long hold-off on request. The hold is counted here, in cycles.
  // ---------------------------------------------------------------------------
  int unsigned ready_hold_left = 0;
  int unsigned ready_run_left  = 0;
  bit          ready_run_high  = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      cell_if.ready <= 1'b0;
    end else begin
      if (holds_done != holds_asked) begin
        holds_done++;
        ready_hold_left = LONG_HOLD;
      end
      if (ready_hold_left != 0) begin
        ready_hold_left--;
        cell_if.ready <= 1'b0;
      end else begin
        if (ready_run_left == 0) begin
          ready_run_high = !ready_run_high;
          if (ready_run_high) begin
            ready_run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 30);
          end else begin
            ready_run_left = idle_cycles() + 1;
          end
        end
        ready_run_left--;
        cell_if.ready <= ready_run_high;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input ccvd_pkg::reg_index_t idx,
                           input logic [ccvd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk); while (!cfg_beat_seen);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [ccvd_pkg::SIZE_W-1:0] cs,
                           input logic [ccvd_pkg::SIZE_W-1:0] cpr,
                           input logic [ccvd_pkg::COLOR_W-1:0] ea,
                           input logic [ccvd_pkg::COLOR_W-1:0] eb,
                           input logic [ccvd_pkg::COLOR_W-1:0] fa,
                           input logic [ccvd_pkg::COLOR_W-1:0] fb,
                           input logic [ccvd_pkg::ENABLE_W-1:0] en);
    write_reg(ccvd_pkg::REG_CELL_SIZE, ccvd_pkg::CFG_DATA_W'(cs));
    write_reg(ccvd_pkg::REG_CELLS_PER_ROW, ccvd_pkg::CFG_DATA_W'(cpr));
    write_reg(ccvd_pkg::REG_EMPTY_COLOR_A, ea);
    write_reg(ccvd_pkg::REG_EMPTY_COLOR_B, eb);
    write_reg(ccvd_pkg::REG_FULL_COLOR_A, fa);
    write_reg(ccvd_pkg::REG_FULL_COLOR_B, fb);
    write_reg(ccvd_pkg::REG_COLOR_ENABLE, ccvd_pkg::CFG_DATA_W'(en));
    stim_colors = '{ea, eb, fa, fb};
  endtask

  task automatic push_pixel(input logic [ccvd_pkg::COLOR_W-1:0] rgb, input logic fs,
                            input int unsigned gap);
    pixel_job_t job;
    job.rgb         = rgb;
    job.frame_start = fs;
    job.gap         = gap;
    pixel_jobs.push_back(job);
    pixels_queued++;
  endtask

  // Mostly programmed colors so the votes go both ways; the rest near misses,
  // random values and the all-zero / all-one corners.
  function automatic logic [ccvd_pkg::COLOR_W-1:0] pick_rgb();
    int unsigned                  r;
    logic [ccvd_pkg::COLOR_W-1:0] c;
    r = $urandom_range(0, 99);
    c = stim_colors[$urandom_range(0, 3)];
    if (r < 55) return c;
    if (r < 70) return c ^ (ccvd_pkg::COLOR_W'(1) << $urandom_range(0, ccvd_pkg::COLOR_W - 1));
    if (r < 95) return ccvd_pkg::COLOR_W'($urandom());
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  // frame_px > 0 marks cell-row boundaries, where a frame start is well formed
  task automatic queue_pixels(input int unsigned n, input bit first_fs,
                              input bit gaps_off, input int unsigned frame_px);
    logic fs;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0) fs = first_fs;
      else if (frame_px != 0 && i % frame_px == 0) fs = ($urandom_range(0, 3) != 0);
      else fs = ($urandom_range(0, 299) == 0);
      push_pixel(pick_rgb(), fs, gaps_off ? 0 : idle_cycles());
    end
  endtask

  // Block idle: every beat taken, every vote in, pipeline given time to empty.
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || pending_votes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------------
  initial begin
    wait (cycles_run >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned                  random_px;
    int unsigned                  cs_eff;
    int unsigned                  cpr_eff;
    int unsigned                  frame_px;
    int unsigned                  n_px;
    int unsigned                  r;
    logic [ccvd_pkg::SIZE_W-1:0]  cs_val;
    logic [ccvd_pkg::SIZE_W-1:0]  cpr_val;
    logic [ccvd_pkg::COLOR_W-1:0] ea;
    logic [ccvd_pkg::COLOR_W-1:0] eb;
    logic [ccvd_pkg::COLOR_W-1:0] fa;
    logic [ccvd_pkg::COLOR_W-1:0] fb;

    pix_if.valid       = 1'b0;
    pix_if.pixel_rgb   = '0;
    pix_if.frame_start = 1'b0;
    cell_if.ready      = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = ccvd_pkg::REG_CELL_SIZE;
    cfg_if.data        = '0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // A few beats on the reset settings, no frame start: position must
    // already be cleared. They stay mid-cell for the next settings.
    queue_pixels(3, 1'b0, 1'b0, 0);
    wait_idle();

    // One-pixel cells, one per row: every beat is a vote. Covers a plain
    // empty hit, a color in both sets (tie, so full), a plain full hit,
    // no hit at all (zero against zero), and the colour corners.
    load_regs(7'd1, 7'd1, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h5A5A5A, 4'hF);
    push_pixel(24'h000000, 1'b0, 0);
    push_pixel(24'hFFFFFF, 1'b0, 1);
    push_pixel(24'h5A5A5A, 1'b0, 0);
    push_pixel(24'h123456, 1'b0, 2);
    push_pixel(24'hFFFFFF, 1'b1, 0);
    push_pixel(24'hA5A5A5, 1'b0, 0);
    push_pixel(24'h000000, 1'b1, 3);
    wait_idle();

    // Zero in both size registers acts as one; only the first empty color on.
    load_regs(7'd0, 7'd0, 24'h000000, 24'h00FF00, 24'hFFFFFF, 24'h0000FF, 4'b0001);
    push_pixel(24'h000000, 1'b1, 0);
    push_pixel(24'hFFFFFF, 1'b0, 0);
    push_pixel(24'h00FF00, 1'b0, 0);
    wait_idle();

    // Oversized row width clips to 64 columns: column 63 closes the row.
    load_regs(7'd1, 7'd127, 24'h00FF00, 24'h000000, 24'hFFFFFF, 24'h0000FF, 4'b0100);
    queue_pixels(64, 1'b1, 1'b0, 64);
    wait_idle();

    // Two-pixel cells across all 64 columns: the first line writes every
    // column entry, so later reads never touch a stale-from-reset entry.
    load_regs(7'd2, 7'd64, ccvd_pkg::COLOR_W'($urandom()), ccvd_pkg::COLOR_W'($urandom()),
              ccvd_pkg::COLOR_W'($urandom()), ccvd_pkg::COLOR_W'($urandom()), 4'hF);
    queue_pixels(256, 1'b1, 1'b0, 256);
    wait_idle();

    // Oversized cell edge clips to 64: a 64-pixel segment per cell, then a
    // few pixels into the second line before the edge shrinks mid-frame.
    ea = ccvd_pkg::COLOR_W'($urandom());
    fa = ccvd_pkg::COLOR_W'($urandom());
    load_regs(7'd127, 7'd2, ea, fa, fa, ea, 4'b1100);
    queue_pixels(138, 1'b1, 1'b0, 0);
    wait_idle();
    // Shrunk edge: the line counter is on the new last line, so the cells of
    // this row close on their next segment end.
    load_regs(7'd2, 7'd2, ea, fa, fa, ea, 4'hF);
    queue_pixels(4, 1'b0, 1'b0, 0);
    wait_idle();

    // Back-pressure: one vote per beat, sender never pauses, receiver holds
    // off for a long stretch so the block fills and stalls its input.
    load_regs(7'd1, 7'd4, ccvd_pkg::COLOR_W'($urandom()), ccvd_pkg::COLOR_W'($urandom()),
              ccvd_pkg::COLOR_W'($urandom()), ccvd_pkg::COLOR_W'($urandom()), 4'hF);
    holds_asked++;
    queue_pixels(80, 1'b1, 1'b1, 4);
    wait_idle();

    // Random settings, mostly whole frames of small cells.
    random_px = 0;
    while (random_px < RANDOM_PIXELS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      cs_val = ccvd_pkg::SIZE_W'($urandom_range(1, 4));
      else if (r < 90) cs_val = ccvd_pkg::SIZE_W'($urandom_range(5, 8));
      else if (r < 95) cs_val = '0;
      else             cs_val = ccvd_pkg::SIZE_W'($urandom_range(9, 16));
      r = $urandom_range(0, 99);
      if (r < 45)      cpr_val = ccvd_pkg::SIZE_W'($urandom_range(1, 8));
      else if (r < 80) cpr_val = ccvd_pkg::SIZE_W'($urandom_range(9, 64));
      else if (r < 90) cpr_val = '0;
      else             cpr_val = ccvd_pkg::SIZE_W'($urandom_range(65, 127));

      cs_eff  = clip_limit(cs_val, CELL_EDGE_MAX);
      cpr_eff = clip_limit(cpr_val, CELL_COLS_MAX);
      // keep a cell row to a few hundred pixels
      if (cs_eff * cs_eff * cpr_eff > 300) begin
        cpr_val = ccvd_pkg::SIZE_W'(300 / (cs_eff * cs_eff));
        cpr_eff = int'(cpr_val);
      end
      frame_px = cs_eff * cs_eff * cpr_eff;
      n_px = frame_px * $urandom_range(1, (600 / frame_px > 3) ? 3 :
                                          (600 / frame_px < 1) ? 1 : 600 / frame_px);
      // now and then cut the frame short
      if ($urandom_range(0, 9) == 0) n_px = $urandom_range(1, n_px);

      ea = ccvd_pkg::COLOR_W'($urandom());
      eb = ($urandom_range(0, 99) < 15) ? ea : ccvd_pkg::COLOR_W'($urandom());
      fa = ($urandom_range(0, 99) < 20) ? ea : ccvd_pkg::COLOR_W'($urandom());
      fb = ($urandom_range(0, 99) < 10) ? eb : ccvd_pkg::COLOR_W'($urandom());
      load_regs(cs_val, cpr_val, ea, eb, fa, fb,
                ccvd_pkg::ENABLE_W'($urandom_range(0, 15)));

      // most phases open a fresh frame; the rest carry on mid-frame
      queue_pixels(n_px, $urandom_range(0, 99) < 85, $urandom_range(0, 4) == 0, frame_px);
      random_px += n_px;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_votes.size() != 0) begin
      $error("%0d cell results never arrived", pending_votes.size());
      fault_count++;
    end

    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
